// File: src/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// Shared constants and types for the frustum plane sphere cull block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_PLANES = 6;
  localparam int DIV_W = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_REBUILD = 2'd1;
  localparam logic [1:0] OP_TEST = 2'd2;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
  } plane_t;

  typedef struct packed {
    logic               vld;
    logic               vis;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic signed [31:0] r;
  } sphere_t;

  typedef struct packed {
    logic               en;
    logic [1:0]         row;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } mat_wr_t;

endpackage

`default_nettype wire

// File: src/fpsc_cell.sv
// ----------------------------------------------------------------------------
// fpsc_cell
// One plane of the cull chain: holds a plane, tests the passing sphere.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_cell
  import fpsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    en,
  input  wire sphere_t tok_in,
  output sphere_t      tok_out,
  input  wire logic    shift_en,
  input  wire plane_t  plane_in,
  output plane_t       plane_out,
  output logic         busy
);

  plane_t             plane_r;
  sphere_t            s1_r;
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic signed [32:0] dr_r;
  sphere_t            tok_r;
  sphere_t            tok_nxt;
  logic signed [65:0] sum;
  logic signed [65:0] dr_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (shift_en) begin
      plane_r <= plane_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld  <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (en) begin
      s1_r  <= tok_in;
      p0_r  <= plane_r.a * tok_in.cx;
      p1_r  <= plane_r.b * tok_in.cy;
      p2_r  <= plane_r.c * tok_in.cz;
      dr_r  <= 33'(plane_r.d) + 33'(tok_in.r);
      tok_r <= tok_nxt;
    end
  end

  assign dr_sh = 66'(dr_r) <<< FRAC_BITS;
  assign sum = 66'(p0_r) + 66'(p1_r) + 66'(p2_r) + dr_sh;

  always_comb begin
    tok_nxt     = s1_r;
    tok_nxt.vis = s1_r.vis & (sum > 66'sd0);
  end

  assign tok_out   = tok_r;
  assign plane_out = plane_r;
  assign busy      = s1_r.vld | tok_r.vld;

endmodule

`default_nettype wire

// File: src/fpsc_rebuild.sv
// ----------------------------------------------------------------------------
// fpsc_rebuild
// Matrix store and plane rebuild sequencer: raw plane, squared length,
// bitwise square root, restoring divide; planes shift into the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_rebuild
  import fpsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mat_wr_t wr,
  input  wire logic    start,
  output logic         busy,
  output logic         shift_en,
  output plane_t       plane_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RAW   = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;

  logic signed [31:0] m_r [4][4];
  logic [2:0]         st_r, st_nxt;
  logic [2:0]         p_r;
  logic [1:0]         k_r;
  logic [CNT_W-1:0]   cnt_r;
  logic signed [31:0] c_r [4];
  logic signed [31:0] nq_r [4];
  logic [63:0]        prod_r;
  logic [63:0]        n_r;
  logic [63:0]        res_r, bit_r;
  logic [31:0]        len_r;
  logic [31:0]        rem_r;
  logic [DIV_W-1:0]   dq_r;

  logic signed [31:0] raw [4];
  logic [31:0]        cmag;
  logic [63:0]        t;
  logic               ge;
  logic [63:0]        n_step, res_step;
  logic [32:0]        rsh;
  logic               qbit;
  logic [31:0]        rem_step;
  logic [DIV_W-1:0]   dq_step;
  logic [DIV_W-1:0]   dividend;
  logic signed [31:0] qfinal;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -33'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (p_r)
        3'd0: raw[k] = sat32(33'(m_r[k][3]) + 33'(m_r[k][0]));
        3'd1: raw[k] = sat32(33'(m_r[k][3]) - 33'(m_r[k][0]));
        3'd2: raw[k] = sat32(33'(m_r[k][3]) - 33'(m_r[k][1]));
        3'd3: raw[k] = sat32(33'(m_r[k][3]) + 33'(m_r[k][1]));
        3'd4: raw[k] = sat32(33'(m_r[k][3]) + 33'(m_r[k][2]));
        default: raw[k] = sat32(33'(m_r[k][3]) - 33'(m_r[k][2]));
      endcase
    end
  end

  assign cmag = mag32(c_r[k_r]);

  assign t        = res_r + bit_r;
  assign ge       = n_r >= t;
  assign n_step   = ge ? (n_r - t) : n_r;
  assign res_step = ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  assign rsh      = {rem_r, dq_r[DIV_W-1]};
  assign qbit     = rsh >= {1'b0, len_r};
  assign rem_step = qbit ? 32'(rsh - {1'b0, len_r}) : rsh[31:0];
  assign dq_step  = {dq_r[DIV_W-2:0], qbit};
  assign dividend = DIV_W'(cmag) << FRAC_BITS;

  always_comb begin
    if (c_r[k_r] == 32'sd0) begin
      qfinal = 32'sd0;
    end else if (c_r[k_r][31]) begin
      if (len_r == 32'd0 || (|dq_step[DIV_W-1:31])) begin
        qfinal = 32'sh8000_0000;
      end else begin
        qfinal = -$signed(dq_step[31:0]);
      end
    end else begin
      if (len_r == 32'd0 || (|dq_step[DIV_W-1:31])) begin
        qfinal = 32'sh7FFF_FFFF;
      end else begin
        qfinal = $signed(dq_step[31:0]);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (start) st_nxt = S_RAW;
      S_RAW:   st_nxt = S_SQ;
      S_SQ:    if (k_r == 2'd3) st_nxt = S_SQRT;
      S_SQRT:  if (cnt_r == CNT_W'(31)) st_nxt = S_DIV;
      S_DIV:   if (cnt_r == CNT_W'(DIV_W - 1) && k_r == 2'd3) st_nxt = S_SHIFT;
      S_SHIFT: st_nxt = (p_r == 3'(NUM_PLANES - 1)) ? S_IDLE : S_RAW;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m_r[i][j] <= '0;
        end
      end
    end else if (wr.en) begin
      m_r[wr.row][0] <= wr.x;
      m_r[wr.row][1] <= wr.y;
      m_r[wr.row][2] <= wr.z;
      m_r[wr.row][3] <= wr.w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      p_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE) begin
        p_r <= '0;
      end else if (st_r == S_SHIFT) begin
        p_r <= p_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_RAW: begin
        for (int k = 0; k < 4; k++) begin
          c_r[k] <= raw[k];
        end
        k_r    <= '0;
        prod_r <= '0;
        n_r    <= '0;
      end
      S_SQ: begin
        n_r    <= n_r + prod_r;
        prod_r <= (k_r == 2'd3) ? 64'd0 : (cmag * cmag);
        k_r    <= k_r + 2'd1;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        cnt_r  <= '0;
      end
      S_SQRT: begin
        n_r   <= n_step;
        res_r <= res_step;
        bit_r <= bit_r >> 2;
        if (cnt_r == CNT_W'(31)) begin
          len_r <= res_step[31:0];
          cnt_r <= '0;
          rem_r <= '0;
          dq_r  <= dividend;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      S_DIV: begin
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          nq_r[k_r] <= qfinal;
          k_r       <= k_r + 2'd1;
          cnt_r     <= '0;
          rem_r     <= '0;
          dq_r      <= DIV_W'(mag32(c_r[k_r + 2'd1])) << FRAC_BITS;
        end else begin
          rem_r <= rem_step;
          dq_r  <= dq_step;
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign busy       = st_r != S_IDLE;
  assign shift_en   = st_r == S_SHIFT;
  assign plane_out  = '{a: nq_r[0], b: nq_r[1], c: nq_r[2], d: nq_r[3]};

endmodule

`default_nettype wire

// File: src/frustum_plane_sphere_cull_top.sv
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull_top
// Frustum plane sphere cull: matrix load, plane rebuild, sphere test.
// ----------------------------------------------------------------------------
// Sphere tests stream at one transfer per cycle, unless the output stall or
// a rebuild holds the input, through a chain of six plane cells, two register
// stages each, plus the output register. Load items give no result. A rebuild
// waits until the cell chain is empty, then runs the rebuild sequencer, per
// plane: the raw plane, its squared length, 32 square root steps, a bit-serial
// divide per component and one shift into the chain. The input stalls while
// the sequencer runs.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_plane_sphere_cull_top
  import fpsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [1:0]  in_row_select,
  input  wire logic [31:0] in_val_x,
  input  wire logic [31:0] in_val_y,
  input  wire logic [31:0] in_val_z,
  input  wire logic [31:0] in_val_w,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_visible
);

  logic                en;
  logic                acc;
  logic                rb_busy;
  logic                shift_en;
  logic                pipe_busy;
  plane_t              rb_plane;
  mat_wr_t             wr;
  sphere_t             tok   [NUM_PLANES+1];
  plane_t              plane [NUM_PLANES+1];
  logic [NUM_PLANES-1:0] cell_busy;
  logic                out_valid_r;
  logic                out_visible_r;

  assign en        = !out_valid_r || !out_stall;
  assign pipe_busy = |cell_busy;
  assign in_stall  = !en || rb_busy || (in_op == OP_REBUILD && pipe_busy);
  assign acc       = in_valid && !in_stall;

  assign wr = '{en: acc && in_op == OP_LOAD, row: in_row_select,
                x: in_val_x, y: in_val_y, z: in_val_z, w: in_val_w};

  assign tok[0]   = '{vld: acc && in_op == OP_TEST, vis: 1'b1,
                      cx: in_val_x, cy: in_val_y, cz: in_val_z, r: in_val_w};
  assign plane[0] = rb_plane;

  fpsc_rebuild u_rebuild (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .start     (acc && in_op == OP_REBUILD),
    .busy      (rb_busy),
    .shift_en  (shift_en),
    .plane_out (rb_plane)
  );

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fpsc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .tok_in    (tok[i]),
      .tok_out   (tok[i+1]),
      .shift_en  (shift_en),
      .plane_in  (plane[i]),
      .plane_out (plane[i+1]),
      .busy      (cell_busy[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r   <= tok[NUM_PLANES].vld;
      out_visible_r <= tok[NUM_PLANES].vis;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    rb_busy |-> in_stall) else $error("input taken during rebuild");

  a_rebuild_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_REBUILD) |-> !pipe_busy)
    else $error("rebuild started with tests in flight");

  a_no_test_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    rb_busy |-> !pipe_busy) else $error("test in chain during rebuild");

  a_rebuild_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_REBUILD) |=> rb_busy)
    else $error("rebuild did not start");
`endif

endmodule

`default_nettype wire

// File: tb/frustum_plane_sphere_cull_top_tb.sv
// ----------------------------------------------------------------------------
// frustum_plane_sphere_cull_top_tb
// Self-checking bench for the frustum plane sphere cull block. A table of
// directed items is followed by random matrix loads, plane rebuilds and
// sphere tests. Every visibility transfer is checked in order against its
// table value or a bit-exact plane and sphere predictor, with random idling.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_plane_sphere_cull_top_tb;
  import fpsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WD_LIMIT = 6000;
  localparam int N_RAND = 1100;
  localparam int N_CALM = 150;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] SMAX = 32'h7fff_ffff;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  row;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    bit          chk;
    bit          vis;
  } cull_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [1:0]  in_row_select;
  logic [31:0] in_val_x;
  logic [31:0] in_val_y;
  logic [31:0] in_val_z;
  logic [31:0] in_val_w;
  logic        out_valid;
  logic        out_stall;
  logic        out_visible;

  logic signed [31:0] mat_q[16];
  logic signed [31:0] plane_q[24];
  bit                 vis_q[$];
  bit                 idle_en;
  int                 long_hold_req;
  int                 fail_cnt;
  int                 wd_cnt;
  cull_item_t         dir_tbl[$];

  frustum_plane_sphere_cull_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_row_select(in_row_select),
    .in_val_x     (in_val_x),
    .in_val_y     (in_val_y),
    .in_val_z     (in_val_z),
    .in_val_w     (in_val_w),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_visible  (out_visible)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] norm_comp(longint c, longint unsigned len);
    longint unsigned mag, q;
    mag = (c < 0) ? longint'(-c) : longint'(c);
    if (c == 0) return 32'd0;
    if (len == 0) return (c > 0) ? SMAX : SMIN;
    q = (mag << FRAC_BITS) / len;
    if (c > 0) return (q > 64'h7fff_ffff) ? SMAX : q[31:0];
    return (q >= 64'h8000_0000) ? SMIN : 32'(-longint'(q));
  endfunction

  task automatic rebuild_planes();
    longint c[4];
    longint a, b;
    longint unsigned sq, mag, len;
    int col;
    bit add;
    for (int p = 0; p < NUM_PLANES; p++) begin
      col = p / 2;
      add = (p == 0) || (p == 3) || (p == 4);
      sq = 0;
      for (int k = 0; k < 4; k++) begin
        a = mat_q[k*4+3];
        b = mat_q[k*4+col];
        c[k] = sat32(add ? a + b : a - b);
      end
      for (int k = 0; k < 3; k++) begin
        mag = (c[k] < 0) ? longint'(-c[k]) : longint'(c[k]);
        sq = sq + mag * mag;
      end
      len = isqrt(sq);
      for (int k = 0; k < 4; k++) plane_q[p*4+k] = norm_comp(c[k], len);
    end
  endtask

  function automatic bit sphere_visible(logic signed [31:0] cx, logic signed [31:0] cy,
                                        logic signed [31:0] cz, logic signed [31:0] r);
    logic signed [95:0] acc, e0, e1, e2, ed, ex, ey, ez, er;
    ex = cx;
    ey = cy;
    ez = cz;
    er = r;
    for (int p = 0; p < NUM_PLANES; p++) begin
      e0 = plane_q[p*4];
      e1 = plane_q[p*4+1];
      e2 = plane_q[p*4+2];
      ed = plane_q[p*4+3];
      acc = e0 * ex + e1 * ey + e2 * ez + ((ed + er) <<< FRAC_BITS);
      if (acc <= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict(cull_item_t it);
    case (it.op)
      OP_LOAD: begin
        mat_q[it.row*4]   = it.x;
        mat_q[it.row*4+1] = it.y;
        mat_q[it.row*4+2] = it.z;
        mat_q[it.row*4+3] = it.w;
      end
      OP_REBUILD: rebuild_planes();
      OP_TEST: vis_q.push_back(it.chk ? it.vis : sphere_visible(it.x, it.y, it.z, it.w));
      default: ;
    endcase
  endtask

  task automatic send_item(cull_item_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= it.op;
    in_row_select <= it.row;
    in_val_x      <= it.x;
    in_val_y      <= it.y;
    in_val_z      <= it.z;
    in_val_w      <= it.w;
    do @(posedge clk); while (in_stall);
    predict(it);
    @(negedge clk);
  endtask

  function automatic cull_item_t mk(logic [1:0] op, logic [1:0] row, logic [31:0] x,
                                    logic [31:0] y, logic [31:0] z, logic [31:0] w,
                                    bit chk = 0, bit vis = 0);
    cull_item_t it;
    it.op = op;
    it.row = row;
    it.x = x;
    it.y = y;
    it.z = z;
    it.w = w;
    it.chk = chk;
    it.vis = vis;
    return it;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1) ? SMAX : SMIN;
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic cull_item_t rand_item();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return mk(OP_LOAD, 2'($urandom), rand_val(), rand_val(), rand_val(),
                           rand_val());
    if (sel < 10) return mk(OP_REBUILD, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    if (sel < 12) return mk(OP_NONE, 2'($urandom), $urandom, $urandom, $urandom, $urandom);
    return mk(OP_TEST, 2'($urandom), rand_val(), rand_val(), rand_val(), rand_val());
  endfunction

  // receiver stall bursts plus one long hold-off
  always @(negedge clk) begin : stall_gen
    static int hold = 0;
    bit s;
    s = 1'b0;
    if (long_hold_req > 0) begin
      hold = long_hold_req;
      long_hold_req = 0;
    end else if (hold == 0 && idle_en && $urandom_range(0, 7) == 0) begin
      hold = $urandom_range(1, 17);
    end
    if (hold > 0) begin
      s = 1'b1;
      hold--;
    end
    out_stall <= s;
  end

  always @(posedge clk) begin : result_check
    bit ev;
    if (rst_n && out_valid && !out_stall) begin
      if (vis_q.size() == 0) begin
        $display("%0t: unexpected transfer, visible %0b", $time, out_visible);
        fail_cnt++;
      end else begin
        ev = vis_q.pop_front();
        if (out_visible !== ev) begin
          $display("%0t: visible mismatch, expected %0b actual %0b", $time, ev, out_visible);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      wd_cnt <= 0;
    end else if (wd_cnt >= WD_LIMIT) begin
      $display("frustum_plane_sphere_cull_top_tb NOT OK");
      $finish;
    end else begin
      wd_cnt <= wd_cnt + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_LOAD;
    in_row_select = 2'd0;
    in_val_x = 32'd0;
    in_val_y = 32'd0;
    in_val_z = 32'd0;
    in_val_w = 32'd0;
    out_stall = 1'b0;
    idle_en = 1'b0;
    long_hold_req = 0;
    fail_cnt = 0;
    wd_cnt = 0;
    foreach (mat_q[i]) mat_q[i] = '0;
    foreach (plane_q[i]) plane_q[i] = '0;

    // all planes zero after reset: visible exactly when radius positive
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd1, 1, 1));
    dir_tbl.push_back(mk(OP_TEST, 2'd3, SMAX, SMIN, SMAX, 32'd0, 1, 0));
    dir_tbl.push_back(mk(OP_TEST, 2'd1, SMIN, SMAX, SMIN, 32'hffff_ffff, 1, 0));
    dir_tbl.push_back(mk(OP_TEST, 2'd2, SMAX, SMAX, SMIN, SMAX, 1, 1));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, ONE, ONE, ONE, SMIN, 1, 0));
    dir_tbl.push_back(mk(OP_NONE, 2'd2, SMAX, SMAX, SMAX, SMAX));
    dir_tbl.push_back(mk(OP_REBUILD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, SMIN, SMIN, SMIN, 32'd1, 1, 1));
    // zero-length normals, positive offset
    dir_tbl.push_back(mk(OP_LOAD, 2'd3, 32'd0, 32'd0, 32'd0, ONE));
    dir_tbl.push_back(mk(OP_REBUILD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, SMAX, SMIN, SMAX, SMIN));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    // saturating raw planes
    dir_tbl.push_back(mk(OP_LOAD, 2'd0, SMAX, SMIN, SMAX, SMAX));
    dir_tbl.push_back(mk(OP_LOAD, 2'd1, SMIN, SMAX, SMIN, SMIN));
    dir_tbl.push_back(mk(OP_REBUILD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, SMAX, SMIN, 32'd0, ONE));
    // identity matrix, unit cube
    dir_tbl.push_back(mk(OP_LOAD, 2'd0, ONE, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_LOAD, 2'd1, 32'd0, ONE, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_LOAD, 2'd2, 32'd0, 32'd0, ONE, 32'd0));
    dir_tbl.push_back(mk(OP_LOAD, 2'd3, 32'd0, 32'd0, 32'd0, ONE));
    dir_tbl.push_back(mk(OP_REBUILD, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'd0, 32'd0, 32'd0, 32'd0));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'h0003_0000, 32'd0, 32'd0, ONE));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'h0002_0000, 32'd0, 32'd0, ONE));
    dir_tbl.push_back(mk(OP_TEST, 2'd0, 32'h0002_0000, 32'd0, 32'd0, 32'h0001_0001));

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tbl[i]) send_item(dir_tbl[i]);

    idle_en = 1'b1;
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - N_CALM) idle_en = 1'b0;
      if (n == 300) long_hold_req = 400;
      if (n == 600) begin
        in_valid <= 1'b0;
        wait (vis_q.size() == 0);
        @(negedge clk);
      end
      send_item(rand_item());
    end
    in_valid <= 1'b0;

    wait (vis_q.size() == 0);
    repeat (1500) @(posedge clk);
    if (fail_cnt == 0 && vis_q.size() == 0) begin
      $display("frustum_plane_sphere_cull_top_tb OK");
    end else begin
      $display("frustum_plane_sphere_cull_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
